/* src/pfba_pkg.sv */
`default_nettype none
package pfba_pkg;

    localparam int MEM_AW_MAX = 16;

    localparam logic [1:0] ACT_ADD_REGION = 2'd0;
    localparam logic [1:0] ACT_ALLOC_ONE  = 2'd1;
    localparam logic [1:0] ACT_ALLOC_RUN  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOMEM = 2'd1;
    localparam logic [1:0] STAT_SKIP  = 2'd2;

    localparam logic [32:0] TYPE_USABLE = 33'h1_0000_0001;
    localparam logic [63:0] LOW_MEM_END = 64'h0000_0000_0010_0000;
    localparam logic [31:0] ALL_USED    = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_AR1,
        ST_AR2,
        ST_ONE_RD,
        ST_ONE_CHK,
        ST_RUN_RD,
        ST_RUN_PROC,
        ST_SW_RD,
        ST_SW_WR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [MEM_AW_MAX-1:0] waddr;
        logic [31:0]           wdata;
        logic                  re;
        logic [MEM_AW_MAX-1:0] raddr;
    } mem_req_t;

endpackage
`default_nettype wire

/* src/pfba_bitmap_ram.sv */
`default_nettype none
module pfba_bitmap_ram #(
    parameter int WORDS = 1024,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire pfba_pkg::mem_req_t req,
    output logic [31:0]           rdata
);
    import pfba_pkg::*;

    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

/* src/page_frame_bitmap_allocator.sv */
`default_nettype none
// One used bit per page frame, 32 frames to a word of a single-port-read
// bitmap RAM. After reset the block sweeps the RAM setting every frame used,
// one word a cycle (WORD_COUNT words, 1024 by default), and stalls input
// until that pass ends. Items are handled one at a time, each yielding one
// result beat. add_region checks and page-aligns the region, then reads and
// writes back each bitmap word it frees; alloc_one reads and checks each word
// from word 0 to the first word with a free frame; alloc_run scans each word
// with one RAM read and four 8-frame steps, then reads and writes back each
// word marked. Each read-modify-write goes through the registered RAM read.
module page_frame_bitmap_allocator #(
    parameter int NUM_FRAMES = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] region_base,
    input  wire logic [63:0] region_length,
    input  wire logic [32:0] region_type_bits,
    input  wire logic [15:0] run_pages,
    input  wire logic [7:0]  alignment,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [14:0]      first_frame
);
    import pfba_pkg::*;

    localparam int WORD_COUNT = (NUM_FRAMES + 31) / 32;
    localparam int WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int FW  = $clog2(NUM_FRAMES) + 1;
    localparam int PB  = $clog2(PAGE_BYTES);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);
    localparam logic [FW-1:0]  NFR = FW'(NUM_FRAMES);

    state_t state_reg, state_next;
    logic [WAW-1:0] cnt_reg, cnt_next;
    logic [1:0]     sub_reg, sub_next;
    logic           out_valid_reg, out_valid_next;

    logic [63:0] base_reg, len_reg, abase_reg, alen_reg;
    logic [63:0] abase_next, alen_next;
    logic [32:0] type_reg;
    logic [15:0] want_reg;
    logic [7:0]  align_reg;
    logic        bad_reg, bad_next;
    logic [FW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic        set_reg, set_next;
    logic        in_run_reg, in_run_next;
    logic [FW-1:0] rs_reg, rs_next, rl_reg, rl_next;
    logic [7:0]  phase_reg, phase_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [14:0] res_frame_reg, res_frame_next;
    logic [1:0]  status_reg, status_next;
    logic [14:0] first_frame_reg, first_frame_next;

    mem_req_t    mem_req;
    logic [31:0] mem_rdata;
    logic        out_free;

    pfba_bitmap_ram #(
        .WORDS (WORD_COUNT),
        .AW    (WAW)
    ) u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign first_frame = first_frame_reg;

    // region alignment arithmetic
    logic [PB-1:0] rem;
    logic [PB:0]   shift;
    logic [64:0]   base_add, len_sub;
    assign rem      = base_reg[PB-1:0];
    assign shift    = (PB+1)'(PAGE_BYTES) - {1'b0, rem};
    assign base_add = {1'b0, base_reg} + 65'(shift);
    assign len_sub  = {1'b0, len_reg} - 65'(shift);

    logic [63:0]   pages, start;
    logic [FW-1:0] pages_c;
    logic [FW:0]   end_sum;
    assign pages   = alen_reg >> PB;
    assign start   = abase_reg >> PB;
    assign pages_c = (pages >= 64'(NUM_FRAMES)) ? NFR : FW'(pages);
    assign end_sum = (FW+1)'(start[FW-1:0]) + (FW+1)'(pages_c);

    // lowest free frame in the word just read
    logic [4:0] zero_pos;
    always_comb
    begin
        zero_pos = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!mem_rdata[i])
            begin
                zero_pos = 5'(i);
            end
        end
    end

    logic [WAW+4:0] one_frame;
    assign one_frame = {cnt_reg, zero_pos};

    // sweep masks
    logic [FW-1:0]  hi_m1;
    logic [WAW-1:0] lo_word, hi_word;
    logic [31:0]    mask_lo, mask_hi, sw_mask;
    assign hi_m1   = hi_reg - 1'b1;
    assign lo_word = WAW'(lo_reg >> 5);
    assign hi_word = WAW'(hi_m1 >> 5);
    assign mask_lo = (cnt_reg == lo_word) ? (ALL_USED << lo_reg[4:0]) : ALL_USED;
    assign mask_hi = (cnt_reg == hi_word) ? (ALL_USED >> (5'd31 - hi_m1[4:0])) : ALL_USED;
    assign sw_mask = mask_lo & mask_hi;

    // run search over eight frames of the current word
    logic          rp_in_run, rp_found;
    logic [FW-1:0] rp_rs, rp_rl;
    logic [7:0]    rp_phase;
    logic [7:0]    rp_byte;
    always_comb
    begin
        logic          aligned;
        logic [FW-1:0] f;
        rp_in_run = in_run_reg;
        rp_rs     = rs_reg;
        rp_rl     = rl_reg;
        rp_phase  = phase_reg;
        rp_found  = 1'b0;
        rp_byte   = mem_rdata[sub_reg*8 +: 8];
        for (int j = 0; j < 8; j++)
        begin
            f       = FW'({cnt_reg, sub_reg, 3'(j)});
            aligned = (align_reg <= 8'd1) || (rp_phase == 8'd0);
            if (!rp_found)
            begin
                if (rp_in_run)
                begin
                    if (!rp_byte[j])
                    begin
                        rp_rl = rp_rl + 1'b1;
                        if (rp_rl == FW'(want_reg))
                        begin
                            rp_found = 1'b1;
                        end
                    end
                    else
                    begin
                        rp_in_run = 1'b0;
                    end
                end
                else if (!rp_byte[j] && aligned)
                begin
                    rp_in_run = 1'b1;
                    rp_rs     = f;
                    rp_rl     = FW'(1);
                    if (want_reg == 16'd1)
                    begin
                        rp_found = 1'b1;
                    end
                end
                if (align_reg > 8'd1)
                begin
                    rp_phase = (rp_phase == align_reg - 8'd1) ? 8'd0 : rp_phase + 8'd1;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_ADD_REGION: state_next = ST_AR1;
                        ACT_ALLOC_ONE:  state_next = ST_ONE_RD;
                        ACT_ALLOC_RUN:
                        begin
                            if (run_pages == 16'd0 || 32'(run_pages) > NUM_FRAMES)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_RUN_RD;
                            end
                        end
                        default:        state_next = ST_FIN;
                    endcase
                end
            end
            ST_AR1:
            begin
                state_next = ST_AR2;
            end
            ST_AR2:
            begin
                if (bad_reg || pages == 64'd0 || start >= 64'(NUM_FRAMES))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_SW_RD;
                end
            end
            ST_ONE_RD:
            begin
                state_next = ST_ONE_CHK;
            end
            ST_ONE_CHK:
            begin
                if (mem_rdata != ALL_USED || cnt_reg == LAST_WORD)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_ONE_RD;
                end
            end
            ST_RUN_RD:
            begin
                state_next = ST_RUN_PROC;
            end
            ST_RUN_PROC:
            begin
                if (rp_found)
                begin
                    state_next = ST_SW_RD;
                end
                else if (sub_reg == 2'd3)
                begin
                    state_next = (cnt_reg == LAST_WORD) ? ST_FIN : ST_RUN_RD;
                end
            end
            ST_SW_RD:
            begin
                state_next = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                state_next = (cnt_reg == hi_word) ? ST_FIN : ST_SW_RD;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        cnt_next         = cnt_reg;
        sub_next         = sub_reg;
        abase_next       = abase_reg;
        alen_next        = alen_reg;
        bad_next         = bad_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        set_next         = set_reg;
        in_run_next      = in_run_reg;
        rs_next          = rs_reg;
        rl_next          = rl_reg;
        phase_next       = phase_reg;
        res_status_next  = res_status_reg;
        res_frame_next   = res_frame_reg;
        status_next      = status_reg;
        first_frame_next = first_frame_reg;
        out_valid_next   = out_valid_reg;
        mem_req          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW_MAX'(cnt_reg);
                mem_req.wdata = ALL_USED;
                cnt_next      = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cnt_next        = '0;
                sub_next        = '0;
                in_run_next     = 1'b0;
                rl_next         = '0;
                phase_next      = '0;
                res_frame_next  = '0;
                res_status_next = STAT_NOMEM;
                if (action == ACT_ALLOC_RUN && run_pages == 16'd0)
                begin
                    res_status_next = STAT_OK;
                end
            end
            ST_AR1:
            begin
                bad_next   = (type_reg != TYPE_USABLE) || (base_reg < LOW_MEM_END)
                           || (rem != '0 && (base_add[64] || len_sub[64]));
                abase_next = (rem != '0) ? base_add[63:0] : base_reg;
                alen_next  = (rem != '0) ? len_sub[63:0] : len_reg;
            end
            ST_AR2:
            begin
                res_frame_next = '0;
                if (bad_reg || pages == 64'd0)
                begin
                    res_status_next = STAT_SKIP;
                end
                else
                begin
                    res_status_next = STAT_OK;
                end
                lo_next  = start[FW-1:0];
                hi_next  = (end_sum > (FW+1)'(NUM_FRAMES)) ? NFR : end_sum[FW-1:0];
                set_next = 1'b0;
                cnt_next = WAW'(start[FW-1:0] >> 5);
            end
            ST_ONE_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = MEM_AW_MAX'(cnt_reg);
            end
            ST_ONE_CHK:
            begin
                if (mem_rdata != ALL_USED)
                begin
                    if (one_frame != '0)
                    begin
                        mem_req.we      = 1'b1;
                        mem_req.waddr   = MEM_AW_MAX'(cnt_reg);
                        mem_req.wdata   = mem_rdata | (32'd1 << zero_pos);
                        res_status_next = STAT_OK;
                        res_frame_next  = 15'(one_frame);
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RUN_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = MEM_AW_MAX'(cnt_reg);
                sub_next      = '0;
            end
            ST_RUN_PROC:
            begin
                in_run_next = rp_in_run;
                rs_next     = rp_rs;
                rl_next     = rp_rl;
                phase_next  = rp_phase;
                sub_next    = sub_reg + 1'b1;
                if (rp_found)
                begin
                    lo_next         = rp_rs;
                    hi_next         = rp_rs + FW'(want_reg);
                    set_next        = 1'b1;
                    cnt_next        = WAW'(rp_rs >> 5);
                    res_status_next = STAT_OK;
                    res_frame_next  = 15'(rp_rs);
                end
                else if (sub_reg == 2'd3)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SW_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = MEM_AW_MAX'(cnt_reg);
            end
            ST_SW_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW_MAX'(cnt_reg);
                mem_req.wdata = set_reg ? (mem_rdata | sw_mask) : (mem_rdata & ~sw_mask);
                cnt_next      = cnt_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    first_frame_next = res_frame_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            base_reg  <= region_base;
            len_reg   <= region_length;
            type_reg  <= region_type_bits;
            want_reg  <= run_pages;
            align_reg <= alignment;
        end
        sub_reg         <= sub_next;
        abase_reg       <= abase_next;
        alen_reg        <= alen_next;
        bad_reg         <= bad_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        set_reg         <= set_next;
        in_run_reg      <= in_run_next;
        rs_reg          <= rs_next;
        rl_reg          <= rl_next;
        phase_reg       <= phase_next;
        res_status_reg  <= res_status_next;
        res_frame_reg   <= res_frame_next;
        status_reg      <= status_next;
        first_frame_reg <= first_frame_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_req.we)
        else $error("bitmap written while idle");

    a_init_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> in_stall)
        else $error("input taken during clear pass");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !out_free) |=> (state_reg == ST_FIN))
        else $error("result dropped while output busy");

    a_fail_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (first_frame == 15'd0))
        else $error("failed request reports a frame");

endmodule
`default_nettype wire
